// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL, removed in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/imu_fp_pkg.sv
// ----------------------------------------------------------------------------
// imu_fp_pkg
// Constants, event codes and shared structs of the IMU frame parser.
// ----------------------------------------------------------------------------
package imu_fp_pkg;

    localparam int unsigned FrameLen   = 11;
    localparam int unsigned StoreDepth = FrameLen - 1;
    localparam int unsigned FillW      = 4;
    localparam int unsigned CntW       = 32;

    localparam logic [7:0] HdrByte   = 8'h55;
    localparam logic [7:0] KindLow   = 8'h50;
    localparam logic [7:0] KindHigh  = 8'h59;
    localparam logic [7:0] KindAngle = 8'h53;
    localparam logic [7:0] KindGyro  = 8'h52;

    localparam logic [FillW-1:0] LastFill  = FillW'(StoreDepth);
    localparam logic [31:0]      GapTimeoutReset = 32'd100;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_ANGLE    = 3'd1,
        EV_GYRO     = 3'd2,
        EV_OTHER    = 3'd3,
        EV_SUM_ERR  = 3'd4,
        EV_KIND_ERR = 3'd5
    } event_t;

    typedef logic [FrameLen-1:0][7:0]   frame_t;
    typedef logic [StoreDepth-1:0][7:0] store_t;

    // verdict on one complete frame
    typedef struct packed {
        event_t             ev;
        logic               good;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic [FillW-1:0]   fill_next;
        store_t             tail;
    } check_res_t;

    typedef struct packed {
        logic gap;
        logic frame;
        logic angle;
        logic gyro;
        logic sum_err;
        logic kind_err;
    } cnt_inc_t;

    typedef struct packed {
        logic [CntW-1:0] bytes;
        logic [CntW-1:0] frames;
        logic [CntW-1:0] angle;
        logic [CntW-1:0] gyro;
        logic [CntW-1:0] sum_err;
        logic [CntW-1:0] kind_err;
        logic [CntW-1:0] gap;
    } counts_t;

endpackage

// File: rtl/imu_fp_in_if.sv
// ----------------------------------------------------------------------------
// imu_fp_in_if
// Request channel: one received byte with its arrival tick.
// ----------------------------------------------------------------------------
interface imu_fp_in_if;

    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [31:0] arrival_tick;

    modport source (output valid, output rx_byte, output arrival_tick, input ready);
    modport sink   (input valid, input rx_byte, input arrival_tick, output ready);

endinterface

// File: rtl/imu_fp_out_if.sv
// ----------------------------------------------------------------------------
// imu_fp_out_if
// Result channel: event, frame values and running counters per byte.
// ----------------------------------------------------------------------------
interface imu_fp_out_if;

    logic               valid;
    logic               ready;
    logic [2:0]         event_res;
    logic               gap_dropped;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [31:0]        byte_count;
    logic [31:0]        frame_count;
    logic [31:0]        angle_count;
    logic [31:0]        gyro_count;
    logic [31:0]        sum_error_count;
    logic [31:0]        kind_error_count;
    logic [31:0]        gap_count;

    modport source (
        output valid, output event_res, output gap_dropped,
        output axis_x, output axis_y, output axis_z,
        output byte_count, output frame_count, output angle_count, output gyro_count,
        output sum_error_count, output kind_error_count, output gap_count,
        input  ready
    );
    modport sink (
        input  valid, input event_res, input gap_dropped,
        input  axis_x, input axis_y, input axis_z,
        input  byte_count, input frame_count, input angle_count, input gyro_count,
        input  sum_error_count, input kind_error_count, input gap_count,
        output ready
    );

endinterface

// File: rtl/imu_fp_check.sv
// ----------------------------------------------------------------------------
// imu_fp_check
// Checks a complete frame: checksum, type, axis values and resync tail.
// ----------------------------------------------------------------------------
module imu_fp_check (
    input  imu_fp_pkg::frame_t     frame,
    output imu_fp_pkg::check_res_t res
);
    import imu_fp_pkg::*;

    logic [7:0]       sum;
    logic             sum_ok;
    logic             kind_ok;
    logic [7:0]       kind;
    logic [FillW-1:0] first;
    logic [4:0]       src_idx [StoreDepth];

    // checksum over bytes 0..9 as a balanced tree
    assign sum = ((frame[0] + frame[1]) + (frame[2] + frame[3]))
               + ((frame[4] + frame[5]) + (frame[6] + frame[7]))
               + (frame[8] + frame[9]);

    assign kind    = frame[1];
    assign sum_ok  = (sum == frame[10]);
    assign kind_ok = (kind >= KindLow) && (kind <= KindHigh);

    // first header byte after position 0, FrameLen when there is none
    always_comb
    begin
        first = FillW'(FrameLen);
        for (int k = FrameLen - 1; k >= 1; k--)
        begin
            if (frame[k] == HdrByte)
            begin
                first = FillW'(k);
            end
        end
    end

    always_comb
    begin
        // shift the frame down so the found header lands at position 0
        for (int j = 0; j < StoreDepth; j++)
        begin
            src_idx[j] = 5'(j) + 5'(first);
            if (src_idx[j] <= 5'(FrameLen - 1))
            begin
                res.tail[j] = frame[src_idx[j][FillW-1:0]];
            end
            else
            begin
                res.tail[j] = 8'h00;
            end
        end
        res.good   = sum_ok && kind_ok;
        res.axis_x = '0;
        res.axis_y = '0;
        res.axis_z = '0;
        if (!sum_ok)
        begin
            res.ev = EV_SUM_ERR;
        end
        else if (!kind_ok)
        begin
            res.ev = EV_KIND_ERR;
        end
        else if (kind == KindAngle || kind == KindGyro)
        begin
            res.ev     = (kind == KindAngle) ? EV_ANGLE : EV_GYRO;
            res.axis_x = {frame[3], frame[2]};
            res.axis_y = {frame[5], frame[4]};
            res.axis_z = {frame[7], frame[6]};
        end
        else
        begin
            res.ev = EV_OTHER;
        end
        res.fill_next = res.good ? '0 : FillW'(FrameLen) - first;
    end

endmodule

// File: rtl/imu_fp_counters.sv
// ----------------------------------------------------------------------------
// imu_fp_counters
// Seven wrapping 32-bit event counters, advanced once per processed byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imu_fp_counters (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  imu_fp_pkg::cnt_inc_t inc,
    output imu_fp_pkg::counts_t  counts
);
    import imu_fp_pkg::*;

    counts_t cnt_reg;
    counts_t cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (en)
        begin
            cnt_next.bytes    = cnt_reg.bytes + CntW'(1);
            cnt_next.frames   = cnt_reg.frames + CntW'(inc.frame);
            cnt_next.angle    = cnt_reg.angle + CntW'(inc.angle);
            cnt_next.gyro     = cnt_reg.gyro + CntW'(inc.gyro);
            cnt_next.sum_err  = cnt_reg.sum_err + CntW'(inc.sum_err);
            cnt_next.kind_err = cnt_reg.kind_err + CntW'(inc.kind_err);
            cnt_next.gap      = cnt_reg.gap + CntW'(inc.gap);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign counts = cnt_reg;

    `ASSERT_NEXT(a_byte_step, clk, rst_n, en, cnt_reg.bytes == $past(cnt_reg.bytes) + CntW'(1))
    `ASSERT_NEXT(a_hold_idle, clk, rst_n, !en, cnt_reg == $past(cnt_reg))
    `ASSERT_IMPLY(a_inc_excl, clk, rst_n, en, $countones({inc.frame, inc.sum_err, inc.kind_err}) <= 1)

endmodule

// File: rtl/imu_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_frame_parser
// Serial frame parser for an inertial sensor byte stream.
// ----------------------------------------------------------------------------
// Every accepted byte yields exactly one result. The byte sits in an input
// register; a single stage (tick gap compare, ten-byte checksum, type test
// and header search for resync) then writes the frame state, the counters
// and the result register, one byte per clock while the result side is
// ready. Results carry the event code, the three axis values of angle and
// gyro frames, and all counters as they stand after that byte. The user
// writes gap_timeout (reset 100) through cfg_we/cfg_wdata only while no
// byte is in flight; the block itself does not enforce this.
module imu_frame_parser (
    input  logic         clk,
    input  logic         rst_n,
    imu_fp_in_if.sink    in_ch,
    imu_fp_out_if.source out_ch,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata
);
    import imu_fp_pkg::*;

    logic               s1_valid_reg, s1_valid_next;
    logic [7:0]         rx_byte_reg;
    logic [31:0]        tick_reg;
    logic [31:0]        timeout_reg;
    logic [31:0]        prev_tick_reg;
    logic [FillW-1:0]   fill_reg, fill_next;
    store_t             store_reg;
    logic               out_valid_reg, out_valid_next;
    event_t             event_reg;
    logic               dropped_reg;
    logic signed [15:0] axis_x_reg, axis_y_reg, axis_z_reg;

    logic               advance;
    logic               proc;
    logic               accept;
    logic               gap_hit;
    logic [FillW-1:0]   fill_eff;
    logic               take;
    logic               complete;
    frame_t             frame;
    check_res_t         chk;
    cnt_inc_t           inc;
    counts_t            counts;

    assign advance     = !out_valid_reg || out_ch.ready;
    assign proc        = s1_valid_reg && advance;
    assign in_ch.ready = !s1_valid_reg || advance;
    assign accept      = in_ch.valid && in_ch.ready;

    assign gap_hit  = (fill_reg != '0) && ((tick_reg - prev_tick_reg) > timeout_reg);
    assign fill_eff = gap_hit ? '0 : fill_reg;
    assign take     = (fill_eff != '0) || (rx_byte_reg == HdrByte);
    assign complete = take && (fill_eff == LastFill);

    always_comb
    begin
        for (int k = 0; k < StoreDepth; k++)
        begin
            frame[k] = store_reg[k];
        end
        frame[FrameLen-1] = rx_byte_reg;
    end

    imu_fp_check u_check (
        .frame (frame),
        .res   (chk)
    );

    always_comb
    begin
        inc.gap      = gap_hit;
        inc.frame    = complete && chk.good;
        inc.angle    = complete && (chk.ev == EV_ANGLE);
        inc.gyro     = complete && (chk.ev == EV_GYRO);
        inc.sum_err  = complete && (chk.ev == EV_SUM_ERR);
        inc.kind_err = complete && (chk.ev == EV_KIND_ERR);
    end

    imu_fp_counters u_counters (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (proc),
        .inc    (inc),
        .counts (counts)
    );

    always_comb
    begin
        if (complete)
        begin
            fill_next = chk.fill_next;
        end
        else if (take)
        begin
            fill_next = fill_eff + FillW'(1);
        end
        else
        begin
            fill_next = fill_eff;
        end
    end

    assign s1_valid_next  = accept ? 1'b1 : (proc ? 1'b0 : s1_valid_reg);
    assign out_valid_next = proc ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
            prev_tick_reg <= '0;
            timeout_reg   <= GapTimeoutReset;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc)
            begin
                fill_reg      <= fill_next;
                prev_tick_reg <= tick_reg;
            end
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    // payload: input register, frame store, result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rx_byte_reg <= in_ch.rx_byte;
            tick_reg    <= in_ch.arrival_tick;
        end
        if (proc)
        begin
            if (complete)
            begin
                // keep the tail starting at the next header
                store_reg <= chk.tail;
            end
            else if (take)
            begin
                store_reg[fill_eff] <= rx_byte_reg;
            end
            event_reg   <= complete ? chk.ev : EV_NONE;
            dropped_reg <= gap_hit;
            axis_x_reg  <= complete ? chk.axis_x : '0;
            axis_y_reg  <= complete ? chk.axis_y : '0;
            axis_z_reg  <= complete ? chk.axis_z : '0;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.event_res        = event_reg;
    assign out_ch.gap_dropped      = dropped_reg;
    assign out_ch.axis_x           = axis_x_reg;
    assign out_ch.axis_y           = axis_y_reg;
    assign out_ch.axis_z           = axis_z_reg;
    assign out_ch.byte_count       = counts.bytes;
    assign out_ch.frame_count      = counts.frames;
    assign out_ch.angle_count      = counts.angle;
    assign out_ch.gyro_count       = counts.gyro;
    assign out_ch.sum_error_count  = counts.sum_err;
    assign out_ch.kind_error_count = counts.kind_err;
    assign out_ch.gap_count        = counts.gap;

    `ASSERT_ALWAYS(a_fill_range, clk, rst_n, fill_reg <= LastFill)
    `ASSERT_IMPLY(a_axes_zero, clk, rst_n, out_valid_reg && event_reg != EV_ANGLE && event_reg != EV_GYRO, axis_x_reg == '0 && axis_y_reg == '0 && axis_z_reg == '0)
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid_reg && !out_ch.ready, out_valid_reg && $stable(counts) && $stable(event_reg))
    `ASSERT_NEXT(a_frame_done, clk, rst_n, proc && complete && chk.good, fill_reg == '0)

endmodule
